// ===== sv/edt_pkg.sv =====
// ----------------------------------------------------------------------------
// edt_pkg: shared definitions for the distance transform block
// Field widths, register indexes, controller states, datapath commands and
// the status bundle returned from the datapath to the controller.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned MAX_COLS_DEF = 256;

  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned DIST_W    = 19;
  // Row distances never exceed rows + cols, which is at most 512 at the default size.
  localparam int unsigned GDIST_W   = 10;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RD,
    S_P1_INIT, S_F_RD, S_F_WR, S_B_INIT, S_B_RD, S_B_WR, S_ROW_NEXT,
    S_P2_INIT, S_COL_INIT, S_GU_RD, S_GU_LAT, S_ST_RD, S_ST_LAT, S_GI_LAT,
    S_SQ, S_CMP, S_POP_CHK, S_PUSH0, S_NUM, S_DIV_START, S_DIV_WAIT, S_PUSH,
    S_U_NEXT, S_BK_INIT, S_BK_RD, S_BK_LAT, S_BK_G, S_BK_WR, S_COL_NEXT
  } state_e;

  typedef enum logic [4:0] {
    C_NOP, C_ACCEPT, C_RD_DONE,
    C_P1_INIT, C_F_WR, C_B_INIT, C_B_RD, C_B_WR, C_ROW_NEXT,
    C_P2_INIT, C_COL_INIT, C_GU_RD, C_GU_LAT, C_GI_LAT, C_SQ, C_CMP,
    C_PUSH0, C_NUM, C_DIV_START, C_PUSH, C_U_NEXT,
    C_BK_INIT, C_BK_G, C_BK_WR, C_COL_NEXT
  } cmd_e;

  typedef struct packed {
    logic in_read;
    logic in_last;
    logic out_busy;
    logic y_end;
    logic y_zero;
    logic x_end;
    logic m_one;
    logic u_last;
    logic u_zero;
    logic qneg;
    logic greater;
    logic div_done;
  } sts_t;

endpackage

// ===== sv/edt_div.sv =====
// ----------------------------------------------------------------------------
// edt_div: iterative signed divider
// Restoring division, one quotient bit per cycle; the quotient is truncated
// toward zero. The divisor is always positive.
// ----------------------------------------------------------------------------
module edt_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic        [DW-1:0] den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   dvd_q;
  logic [DW-1:0]   rem_q, den_q;

  logic [DW:0]     trial, trial_sub;
  logic            fits;

  assign trial     = {rem_q, dvd_q[NW-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      dvd_q <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], fits};
      rem_q <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

// ===== sv/edt_dp.sv =====
// ----------------------------------------------------------------------------
// edt_dp: distance transform datapath
// Configuration registers, pixel and row-distance memories, envelope stack,
// scan counters, squarers and the separation divider.
// ----------------------------------------------------------------------------
module edt_dp #(
  parameter int unsigned MAX_ROWS = edt_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = edt_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  edt_pkg::cmd_e                      cmd_i,
  output edt_pkg::sts_t                      sts_o,
  input  logic                               cfg_valid_i,
  input  logic [edt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [edt_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               operation_i,
  input  logic [edt_pkg::COORD_W-1:0]        row_i,
  input  logic [edt_pkg::COORD_W-1:0]        col_i,
  input  logic                               feature_i,
  input  logic                               last_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [edt_pkg::DIST_W-1:0]         squared_distance_o
);

  localparam int unsigned GW   = edt_pkg::GDIST_W;
  localparam int unsigned DSW  = edt_pkg::DIST_W;
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned MW   = (RW > CW) ? RW : CW;
  localparam int unsigned XW   = ((MW > edt_pkg::CFG_W) ? MW : edt_pkg::CFG_W) + 1;
  localparam int unsigned SQW  = 2 * XW + 2;
  localparam int unsigned NW   = SQW + 2;
  localparam int unsigned DENW = XW + 1;
  localparam int unsigned AW   = RW + CW;

  // Configuration and scan state.
  logic [edt_pkg::CFG_W-1:0] rows_q, cols_q;
  logic [XW-1:0] x_q, y_q, u_q;
  logic [GW-1:0] prev_q;
  logic [RW-1:0] q_q;
  logic          qneg_q;
  logic          out_valid_q;

  // Payload registers.
  logic [SQW-1:0] sq_a_q, sq_b_q, sq_c_q, sq_d_q, sq_e_q, sq_f_q;
  logic           inside_q;
  logic [DSW-1:0] out_data_q;

  // Memories.
  logic [DSW-1:0] pix_mem [2**AW];
  logic [GW-1:0]  rd_mem [2**AW];
  logic [RW-1:0]  site_mem [MAX_ROWS];
  logic [XW-1:0]  start_mem [MAX_ROWS];
  logic [DSW-1:0] pix_rdata_q;
  logic [GW-1:0]  rd_rdata_q;
  logic [RW-1:0]  st_site_q;
  logic [XW-1:0]  st_start_q;

  logic [XW-1:0] rows_x, cols_x, m, n, row_x, col_x, site_x;
  logic [GW-1:0] inf;
  logic          inside_in;

  assign rows_x = XW'(rows_q);
  assign cols_x = XW'(cols_q);
  assign m = (rows_x == '0) ? XW'(1) : ((rows_x > XW'(MAX_ROWS)) ? XW'(MAX_ROWS) : rows_x);
  assign n = (cols_x == '0) ? XW'(1) : ((cols_x > XW'(MAX_COLS)) ? XW'(MAX_COLS) : cols_x);
  assign inf = GW'(m + n);

  assign row_x     = XW'(row_i);
  assign col_x     = XW'(col_i);
  assign inside_in = (row_x < m) && (col_x < n);
  assign site_x    = XW'(st_site_q);

  // Row scan arithmetic.
  logic [GW:0]   prev_inc;
  logic [GW-1:0] fwd_val, bwd_val;

  assign prev_inc = {1'b0, prev_q} + (GW + 1)'(1);
  assign fwd_val  = (pix_rdata_q != '0) ? '0 :
                    ((prev_inc > {1'b0, inf}) ? inf : prev_inc[GW-1:0]);
  assign bwd_val  = ({1'b0, rd_rdata_q} > prev_inc) ? prev_inc[GW-1:0] : rd_rdata_q;

  // Squarers.
  logic signed [XW:0]     dx_s, dxu_s;
  logic signed [2*XW+1:0] dxsq, dxusq;
  logic [XW-1:0]          dxu_a;
  logic [2*GW-1:0]        gsq;
  logic [2*XW-1:0]        usq_w, isq_w;

  assign dx_s  = $signed({1'b0, st_start_q}) - $signed({1'b0, site_x});
  assign dxsq  = dx_s * dx_s;
  assign dxu_a = (cmd_i == edt_pkg::C_BK_G) ? site_x : st_start_q;
  assign dxu_s = $signed({1'b0, dxu_a}) - $signed({1'b0, u_q});
  assign dxusq = dxu_s * dxu_s;
  assign gsq   = rd_rdata_q * rd_rdata_q;
  assign usq_w = u_q * u_q;
  assign isq_w = site_x * site_x;

  logic [SQW:0]   sum_ab, sum_cd;
  logic [DSW-1:0] dist_sat;

  assign sum_ab   = {1'b0, sq_a_q} + {1'b0, sq_b_q};
  assign sum_cd   = {1'b0, sq_c_q} + {1'b0, sq_d_q};
  assign dist_sat = (sum_ab > (SQW + 1)'(edt_pkg::DIST_MAX)) ? edt_pkg::DIST_MAX
                                                             : sum_ab[DSW-1:0];

  // Separation between the stack top and the new site.
  logic signed [NW-1:0] num, quot;
  logic [DENW-1:0]      den;
  logic                 div_done;
  logic signed [NW:0]   w, m_s;
  logic                 push_ok;
  logic [XW-1:0]        w_start;
  logic [RW-1:0]        q_inc;

  assign num = $signed({2'b00, sq_e_q}) - $signed({2'b00, sq_f_q})
             + $signed({2'b00, sq_d_q}) - $signed({2'b00, sq_b_q});
  assign den = {u_q - site_x, 1'b0};

  edt_div #(
    .NW(NW),
    .DW(DENW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i == edt_pkg::C_DIV_START),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign w       = $signed({quot[NW-1], quot}) + $signed((NW + 1)'(1));
  assign m_s     = $signed({{(NW + 1 - XW){1'b0}}, m});
  assign push_ok = (w < m_s) && (q_q != RW'(MAX_ROWS - 1));
  assign w_start = w[NW] ? '0 : w[XW-1:0];
  assign q_inc   = q_q + RW'(1);

  // Memory ports.
  logic [AW-1:0]  pix_raddr, pix_waddr, rd_raddr, rd_waddr;
  logic           pix_we, rd_we, st_we;
  logic [DSW-1:0] pix_wdata;
  logic [GW-1:0]  rd_wdata;
  logic [RW-1:0]  st_raddr, st_waddr, st_wsite;
  logic [XW-1:0]  st_wstart;

  always_comb begin
    pix_raddr = {x_q[RW-1:0], y_q[CW-1:0]};
    pix_waddr = {u_q[RW-1:0], y_q[CW-1:0]};
    pix_wdata = dist_sat;
    pix_we    = 1'b0;
    rd_raddr  = {st_site_q, y_q[CW-1:0]};
    rd_waddr  = {x_q[RW-1:0], y_q[CW-1:0]};
    rd_wdata  = fwd_val;
    rd_we     = 1'b0;
    st_raddr  = qneg_q ? '0 : q_q;
    st_waddr  = '0;
    st_wsite  = '0;
    st_wstart = '0;
    st_we     = 1'b0;
    case (cmd_i)
      edt_pkg::C_ACCEPT: begin
        pix_raddr = {row_x[RW-1:0], col_x[CW-1:0]};
        pix_waddr = {row_x[RW-1:0], col_x[CW-1:0]};
        pix_wdata = DSW'(feature_i);
        pix_we    = (operation_i == edt_pkg::OP_LOAD) && inside_in;
      end
      edt_pkg::C_F_WR: rd_we = 1'b1;
      edt_pkg::C_B_RD: rd_raddr = {x_q[RW-1:0], y_q[CW-1:0]};
      edt_pkg::C_B_WR: begin
        rd_wdata = bwd_val;
        rd_we    = 1'b1;
      end
      edt_pkg::C_GU_RD: rd_raddr = {u_q[RW-1:0], y_q[CW-1:0]};
      edt_pkg::C_COL_INIT: st_we = 1'b1;
      edt_pkg::C_PUSH0: begin
        st_wsite = u_q[RW-1:0];
        st_we    = 1'b1;
      end
      edt_pkg::C_PUSH: begin
        st_waddr  = q_inc;
        st_wsite  = u_q[RW-1:0];
        st_wstart = w_start;
        st_we     = push_ok;
      end
      edt_pkg::C_BK_WR: pix_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rdata_q <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rd_we) begin
      rd_mem[rd_waddr] <= rd_wdata;
    end
    rd_rdata_q <= rd_mem[rd_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      site_mem[st_waddr]  <= st_wsite;
      start_mem[st_waddr] <= st_wstart;
    end
    st_site_q  <= site_mem[st_raddr];
    st_start_q <= start_mem[st_raddr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= edt_pkg::CFG_W'(256);
      cols_q      <= edt_pkg::CFG_W'(256);
      x_q         <= '0;
      y_q         <= '0;
      u_q         <= '0;
      prev_q      <= '0;
      q_q         <= '0;
      qneg_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == edt_pkg::REG_IMAGE_ROWS) begin
          rows_q <= cfg_data_i;
        end else if (cfg_index_i == edt_pkg::REG_IMAGE_COLS) begin
          cols_q <= cfg_data_i;
        end
      end
      if (cmd_i == edt_pkg::C_RD_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        edt_pkg::C_P1_INIT: begin
          x_q    <= '0;
          y_q    <= '0;
          prev_q <= inf;
        end
        edt_pkg::C_F_WR: begin
          prev_q <= fwd_val;
          if (y_q != n - XW'(1)) y_q <= y_q + XW'(1);
        end
        edt_pkg::C_B_INIT: begin
          if (y_q != '0) y_q <= y_q - XW'(1);
        end
        edt_pkg::C_B_WR: begin
          prev_q <= bwd_val;
          if (y_q != '0) y_q <= y_q - XW'(1);
        end
        edt_pkg::C_ROW_NEXT: begin
          if (x_q != m - XW'(1)) begin
            x_q    <= x_q + XW'(1);
            y_q    <= '0;
            prev_q <= inf;
          end
        end
        edt_pkg::C_P2_INIT: y_q <= '0;
        edt_pkg::C_COL_INIT: begin
          q_q    <= '0;
          qneg_q <= 1'b0;
          u_q    <= XW'(1);
        end
        edt_pkg::C_CMP: begin
          if (sum_ab > sum_cd) begin
            if (q_q == '0) qneg_q <= 1'b1;
            else q_q <= q_q - RW'(1);
          end
        end
        edt_pkg::C_PUSH0: begin
          q_q    <= '0;
          qneg_q <= 1'b0;
        end
        edt_pkg::C_PUSH: begin
          if (push_ok) q_q <= q_inc;
        end
        edt_pkg::C_U_NEXT: u_q <= u_q + XW'(1);
        edt_pkg::C_BK_INIT: u_q <= m - XW'(1);
        edt_pkg::C_BK_WR: begin
          if (u_q == st_start_q) begin
            if (qneg_q || q_q == '0) begin
              qneg_q <= 1'b1;
            end else begin
              q_q    <= q_q - RW'(1);
              qneg_q <= 1'b0;
            end
          end
          if (u_q != '0) u_q <= u_q - XW'(1);
        end
        edt_pkg::C_COL_NEXT: begin
          if (y_q != n - XW'(1)) y_q <= y_q + XW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      edt_pkg::C_ACCEPT:  inside_q <= inside_in;
      edt_pkg::C_RD_DONE: out_data_q <= inside_q ? pix_rdata_q : '0;
      edt_pkg::C_GU_LAT:  sq_d_q <= SQW'(gsq);
      edt_pkg::C_GI_LAT: begin
        sq_a_q <= $unsigned(dxsq);
        sq_b_q <= SQW'(gsq);
      end
      edt_pkg::C_SQ: sq_c_q <= $unsigned(dxusq);
      edt_pkg::C_NUM: begin
        sq_e_q <= SQW'(usq_w);
        sq_f_q <= SQW'(isq_w);
      end
      edt_pkg::C_BK_G: begin
        sq_a_q <= $unsigned(dxusq);
        sq_b_q <= SQW'(gsq);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.in_read  = operation_i == edt_pkg::OP_READ;
    sts_o.in_last  = last_i;
    sts_o.out_busy = out_valid_q;
    sts_o.y_end    = y_q == n - XW'(1);
    sts_o.y_zero   = y_q == '0;
    sts_o.x_end    = x_q == m - XW'(1);
    sts_o.m_one    = m == XW'(1);
    sts_o.u_last   = u_q == m - XW'(1);
    sts_o.u_zero   = u_q == '0;
    sts_o.qneg     = qneg_q;
    sts_o.greater  = sum_ab > sum_cd;
    sts_o.div_done = div_done;
  end

  assign out_valid_o        = out_valid_q;
  assign squared_distance_o = out_data_q;

endmodule

// ===== sv/edt_ctrl.sv =====
// ----------------------------------------------------------------------------
// edt_ctrl: distance transform sequencer
// Walks the load/read handshake, the row scans and the column envelope scans,
// issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module edt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  edt_pkg::sts_t  sts_i,
  output edt_pkg::cmd_e  cmd_o
);

  edt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= edt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = edt_pkg::C_NOP;
    in_stall_o = 1'b1;
    case (state_q)
      edt_pkg::S_IDLE: begin
        in_stall_o = sts_i.out_busy;
        if (in_valid_i && !sts_i.out_busy) begin
          cmd_o = edt_pkg::C_ACCEPT;
          if (sts_i.in_read) state_d = edt_pkg::S_RD;
          else if (sts_i.in_last) state_d = edt_pkg::S_P1_INIT;
        end
      end
      edt_pkg::S_RD: begin
        cmd_o   = edt_pkg::C_RD_DONE;
        state_d = edt_pkg::S_IDLE;
      end
      edt_pkg::S_P1_INIT: begin
        cmd_o   = edt_pkg::C_P1_INIT;
        state_d = edt_pkg::S_F_RD;
      end
      edt_pkg::S_F_RD: state_d = edt_pkg::S_F_WR;
      edt_pkg::S_F_WR: begin
        cmd_o   = edt_pkg::C_F_WR;
        state_d = sts_i.y_end ? edt_pkg::S_B_INIT : edt_pkg::S_F_RD;
      end
      edt_pkg::S_B_INIT: begin
        cmd_o   = edt_pkg::C_B_INIT;
        state_d = sts_i.y_zero ? edt_pkg::S_ROW_NEXT : edt_pkg::S_B_RD;
      end
      edt_pkg::S_B_RD: begin
        cmd_o   = edt_pkg::C_B_RD;
        state_d = edt_pkg::S_B_WR;
      end
      edt_pkg::S_B_WR: begin
        cmd_o   = edt_pkg::C_B_WR;
        state_d = sts_i.y_zero ? edt_pkg::S_ROW_NEXT : edt_pkg::S_B_RD;
      end
      edt_pkg::S_ROW_NEXT: begin
        cmd_o   = edt_pkg::C_ROW_NEXT;
        state_d = sts_i.x_end ? edt_pkg::S_P2_INIT : edt_pkg::S_F_RD;
      end
      edt_pkg::S_P2_INIT: begin
        cmd_o   = edt_pkg::C_P2_INIT;
        state_d = edt_pkg::S_COL_INIT;
      end
      edt_pkg::S_COL_INIT: begin
        cmd_o   = edt_pkg::C_COL_INIT;
        state_d = sts_i.m_one ? edt_pkg::S_BK_INIT : edt_pkg::S_GU_RD;
      end
      edt_pkg::S_GU_RD: begin
        cmd_o   = edt_pkg::C_GU_RD;
        state_d = edt_pkg::S_GU_LAT;
      end
      edt_pkg::S_GU_LAT: begin
        cmd_o   = edt_pkg::C_GU_LAT;
        state_d = edt_pkg::S_ST_RD;
      end
      edt_pkg::S_ST_RD: state_d = edt_pkg::S_ST_LAT;
      edt_pkg::S_ST_LAT: state_d = edt_pkg::S_GI_LAT;
      edt_pkg::S_GI_LAT: begin
        cmd_o   = edt_pkg::C_GI_LAT;
        state_d = edt_pkg::S_SQ;
      end
      edt_pkg::S_SQ: begin
        cmd_o   = edt_pkg::C_SQ;
        state_d = edt_pkg::S_CMP;
      end
      edt_pkg::S_CMP: begin
        cmd_o   = edt_pkg::C_CMP;
        state_d = sts_i.greater ? edt_pkg::S_POP_CHK : edt_pkg::S_NUM;
      end
      edt_pkg::S_POP_CHK: begin
        state_d = sts_i.qneg ? edt_pkg::S_PUSH0 : edt_pkg::S_ST_RD;
      end
      edt_pkg::S_PUSH0: begin
        cmd_o   = edt_pkg::C_PUSH0;
        state_d = edt_pkg::S_U_NEXT;
      end
      edt_pkg::S_NUM: begin
        cmd_o   = edt_pkg::C_NUM;
        state_d = edt_pkg::S_DIV_START;
      end
      edt_pkg::S_DIV_START: begin
        cmd_o   = edt_pkg::C_DIV_START;
        state_d = edt_pkg::S_DIV_WAIT;
      end
      edt_pkg::S_DIV_WAIT: begin
        if (sts_i.div_done) state_d = edt_pkg::S_PUSH;
      end
      edt_pkg::S_PUSH: begin
        cmd_o   = edt_pkg::C_PUSH;
        state_d = edt_pkg::S_U_NEXT;
      end
      edt_pkg::S_U_NEXT: begin
        cmd_o   = edt_pkg::C_U_NEXT;
        state_d = sts_i.u_last ? edt_pkg::S_BK_INIT : edt_pkg::S_GU_RD;
      end
      edt_pkg::S_BK_INIT: begin
        cmd_o   = edt_pkg::C_BK_INIT;
        state_d = edt_pkg::S_BK_RD;
      end
      edt_pkg::S_BK_RD: state_d = edt_pkg::S_BK_LAT;
      edt_pkg::S_BK_LAT: state_d = edt_pkg::S_BK_G;
      edt_pkg::S_BK_G: begin
        cmd_o   = edt_pkg::C_BK_G;
        state_d = edt_pkg::S_BK_WR;
      end
      edt_pkg::S_BK_WR: begin
        cmd_o   = edt_pkg::C_BK_WR;
        state_d = sts_i.u_zero ? edt_pkg::S_COL_NEXT : edt_pkg::S_BK_RD;
      end
      edt_pkg::S_COL_NEXT: begin
        cmd_o   = edt_pkg::C_COL_NEXT;
        state_d = sts_i.y_end ? edt_pkg::S_IDLE : edt_pkg::S_COL_INIT;
      end
      default: state_d = edt_pkg::S_IDLE;
    endcase
  end

  // The input side stays closed for the whole transform.
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != edt_pkg::S_IDLE) |-> in_stall_o)
    else $error("input accepted while the transform runs");

  // A transaction is only taken on a real handshake.
  a_accept_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == edt_pkg::C_ACCEPT) |-> (in_valid_i && !in_stall_o))
    else $error("accept command without a handshake");

  // A read always leaves a result in the output register.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == edt_pkg::S_RD) |=> sts_i.out_busy)
    else $error("read finished without a result");

endmodule

// ===== sv/euclidean_distance_transform_2d.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_transform_2d: squared distance transform of a binary image
// Loads a binary image, computes every pixel's squared Euclidean distance to
// the nearest feature pixel and serves read transactions from the result.
// ----------------------------------------------------------------------------
// A load transaction stores one pixel when it is accepted; the load that
// carries last starts the transform, and the input stays stalled until it is
// done. A read transaction's pixel is read into the memory output register and
// then copied into the output register, and the next transaction is not taken
// until that result has been handed off. The transform runs from memories with
// one read and one write port and one iterative divider: phase one runs a
// forward and a backward row scan, each step a read and a write, and phase
// two, per column, compares each row with the envelope stack top, pops the
// entries that the row overtakes, runs one divide unless the stack empties,
// and ends with a write-back scan. Results saturate at 2^19-1, a featureless
// image yields (rows+cols)^2, and reads outside the rows x cols region in use
// return zero.
// Configuration writes are always accepted and must only be issued while no
// transaction is in progress.
module euclidean_distance_transform_2d #(
  parameter int unsigned MAX_ROWS = edt_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = edt_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [edt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edt_pkg::CFG_W-1:0]     cfg_data_i,
  // Input transactions.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [edt_pkg::COORD_W-1:0]   row_i,
  input  logic [edt_pkg::COORD_W-1:0]   col_i,
  input  logic                          feature_i,
  input  logic                          last_i,
  // Result transactions.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [edt_pkg::DIST_W-1:0]    squared_distance_o
);

  edt_pkg::cmd_e cmd;
  edt_pkg::sts_t sts;

  // The register file never holds off a write.
  assign cfg_ready_o = 1'b1;

  edt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  edt_dp #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .feature_i         (feature_i),
    .last_i            (last_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .squared_distance_o(squared_distance_o)
  );

endmodule
